@@ rtl/integer_to_radix_ascii_defines.svh @@
//------------------------------------------------------------------------------
// integer_to_radix_ascii_defines
// Assertion macros shared by the integer-to-ASCII converter RTL.
//------------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_ASCII_DEFINES_SVH
`define INTEGER_TO_RADIX_ASCII_DEFINES_SVH

// expr must hold at every clock edge out of reset
`define IRA_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// cons must hold in the cycle after ante
`define IRA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/ira_pkg.sv @@
//------------------------------------------------------------------------------
// ira_pkg
// Types and constants of the integer-to-ASCII converter.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ira_pkg;

   localparam int DIGIT_W = 6;
   localparam int CHAR_W  = 7;

   localparam logic [DIGIT_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [DIGIT_W-1:0] RADIX_MAX = 6'd36;
   localparam logic [DIGIT_W-1:0] RADIX_DEC = 6'd10;
   localparam logic [DIGIT_W-1:0] DIGIT_MAX_NUM = 6'd9;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] dx;
      dx = {1'b0, d};
      if (d > DIGIT_MAX_NUM) begin
         return dx + CHAR_A - 7'd10;
      end
      return dx + CHAR_ZERO;
   endfunction

endpackage

`default_nettype wire

@@ rtl/ira_ram.sv @@
//------------------------------------------------------------------------------
// ira_ram
// Generic single-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ira_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/integer_to_radix_ascii.sv @@
//------------------------------------------------------------------------------
// integer_to_radix_ascii
// Converts an integer to ASCII digits in radix 2..36, most significant first.
//
// Usage:
//   Pulse start with req_value/req_base while busy is low; that beat is taken.
//   Base 0/1 acts as 2, base above 36 acts as 36. In base ten a negative value
//   gets a leading '-'; every other base reads the bits as unsigned.
//   Characters come out on rsp_character with rsp_valid high for one cycle
//   each; rsp_last marks the final character. The receiver cannot stall.
//   Operation: each digit costs one bit-serial shift-subtract division
//   (one quotient bit per cycle through the remainder register), then a
//   '-' is sent if negative and each digit is read back from the digit RAM
//   (registered read port) through a fetch state and an output state. The
//   last beat is on the port with busy already low, so the next beat can be
//   taken at the edge ending it. One beat in flight at a time.
//   Reset: synchronous, clears the control path; no clearing pass needed.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "integer_to_radix_ascii_defines.svh"

module integer_to_radix_ascii
   import ira_pkg::*;
#(
   parameter int VALUE_BITS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [VALUE_BITS-1:0] req_value,
   input  wire logic [DIGIT_W-1:0]    req_base,
   output logic                       rsp_valid,
   output logic      [CHAR_W-1:0]     rsp_character,
   output logic                       rsp_last
);

   localparam int BIT_W  = $clog2(VALUE_BITS);
   localparam int ADDR_W = $clog2(VALUE_BITS);
   localparam int CNT_W  = $clog2(VALUE_BITS + 1);
   localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(VALUE_BITS - 1);

   typedef enum logic [2:0] {S_IDLE, S_DIV, S_SIGN, S_FETCH, S_OUT} state_type;

   state_type             state_ff,   state_in;
   logic [VALUE_BITS-1:0] mag_ff,     mag_in;
   logic [DIGIT_W-1:0]    radix_ff,   radix_in;
   logic [DIGIT_W-1:0]    rem_ff,     rem_in;
   logic [BIT_W-1:0]      bit_ff,     bit_in;
   logic                  qnz_ff,     qnz_in;
   logic                  neg_ff,     neg_in;
   logic [CNT_W-1:0]      count_ff,   count_in;
   logic [ADDR_W-1:0]     idx_ff,     idx_in;
   logic                  valid_ff,   valid_in;
   logic                  last_ff,    last_in;
   logic [CHAR_W-1:0]     char_ff,    char_in;

   logic [DIGIT_W:0]      trial;
   logic                  q_bit;
   logic [DIGIT_W:0]      rem_next;
   logic                  wr_en;
   logic [DIGIT_W-1:0]    rd_data;
   logic                  is_neg;

   assign trial    = {rem_ff, mag_ff[VALUE_BITS-1]};
   assign q_bit    = trial >= {1'b0, radix_ff};
   assign rem_next = q_bit ? trial - {1'b0, radix_ff} : trial;
   assign wr_en    = (state_ff == S_DIV) && (bit_ff == BIT_LAST);
   assign is_neg   = req_value[VALUE_BITS-1] && (req_base == RADIX_DEC);

   ira_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (VALUE_BITS)
   ) u_digits (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (rem_next[DIGIT_W-1:0]),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      radix_in = radix_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      qnz_in   = qnz_ff;
      neg_in   = neg_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      valid_in = 1'b0;
      last_in  = last_ff;
      char_in  = char_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_DIV;
               neg_in   = is_neg;
               mag_in   = is_neg ? ~req_value + 1'b1 : req_value;
               if (req_base < RADIX_MIN) begin
                  radix_in = RADIX_MIN;
               end else if (req_base > RADIX_MAX) begin
                  radix_in = RADIX_MAX;
               end else begin
                  radix_in = req_base;
               end
               rem_in   = '0;
               bit_in   = '0;
               qnz_in   = 1'b0;
               count_in = '0;
            end
         end
         S_DIV: begin
            rem_in = rem_next[DIGIT_W-1:0];
            mag_in = {mag_ff[VALUE_BITS-2:0], q_bit};
            qnz_in = qnz_ff | q_bit;
            bit_in = bit_ff + 1'b1;
            if (bit_ff == BIT_LAST) begin
               rem_in   = '0;
               bit_in   = '0;
               qnz_in   = 1'b0;
               count_in = count_ff + 1'b1;
               idx_in   = count_ff[ADDR_W-1:0];
               if (!(qnz_ff | q_bit)) begin
                  state_in = neg_ff ? S_SIGN : S_FETCH;
               end
            end
         end
         S_SIGN: begin
            valid_in = 1'b1;
            last_in  = 1'b0;
            char_in  = CHAR_MINUS;
            state_in = S_FETCH;
         end
         S_FETCH: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            valid_in = 1'b1;
            char_in  = digit_char(rd_data);
            last_in  = (idx_ff == '0);
            if (idx_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               idx_in   = idx_ff - 1'b1;
               state_in = S_FETCH;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
      mag_ff   <= mag_in;
      radix_ff <= radix_in;
      rem_ff   <= rem_in;
      bit_ff   <= bit_in;
      qnz_ff   <= qnz_in;
      neg_ff   <= neg_in;
      idx_ff   <= idx_in;
      last_ff  <= last_in;
      char_ff  <= char_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

   `IRA_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "not busy after accept")
   `IRA_ASSERT_NEXT(a_strobe_spacing, rsp_valid, !rsp_valid, "back-to-back result strobes")
   `IRA_ASSERT_ALWAYS(a_count_range, count_ff <= CNT_W'(VALUE_BITS), "digit count overflow")
   `IRA_ASSERT_ALWAYS(a_last_ends_item, !(rsp_valid && rsp_last) || !busy, "busy on last beat")

endmodule

`default_nettype wire

@@ bench/tb.sv @@
//------------------------------------------------------------------------------
// tb
// Self-checking bench for integer_to_radix_ascii. Directed corner values and
// random integers on base codes 0..63 go in through start/busy, and every
// character strobe is checked against a digit-string model kept in the bench.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   import ira_pkg::*;

   localparam int VALUE_BITS    = 64;
   localparam int RANDOM_ITEMS  = 200;
   localparam int CYCLE_LIMIT   = 5_000_000;
   localparam int TAIL_CYCLES   = 200;
   localparam int MAX_PRINTS    = 40;

   typedef struct {
      logic [VALUE_BITS-1:0] value;
      logic [DIGIT_W-1:0]    base;
      bit                    drain_first;
   } conversion_type;

   typedef struct {
      logic [CHAR_W-1:0] code;
      logic              is_last;
   } ascii_char_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [VALUE_BITS-1:0] req_value;
   logic [DIGIT_W-1:0]    req_base;
   logic                  rsp_valid;
   logic [CHAR_W-1:0]     rsp_character;
   logic                  rsp_last;

   conversion_type pending_items[$];
   ascii_char_type expected_chars[$];

   int unsigned beats_issued   = 0;
   int unsigned beats_taken    = 0;
   int unsigned chars_seen     = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned decimal_count  = 0;
   int unsigned minus_count    = 0;
   int unsigned clamped_count  = 0;
   int unsigned longest_string = 0;
   int unsigned total_items    = 0;
   int unsigned burst_left     = 1;
   int unsigned gap_left       = 0;

   always #5 clock = ~clock;

   integer_to_radix_ascii #(
      .VALUE_BITS(VALUE_BITS)
   ) uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_value    (req_value),
      .req_base     (req_base),
      .rsp_valid    (rsp_valid),
      .rsp_character(rsp_character),
      .rsp_last     (rsp_last)
   );

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS) begin
         $display("ERROR @%0t: %s", $time, what);
      end
   endtask

   // queue the character string of one accepted beat, most significant first
   function automatic void predict_ascii(input logic [VALUE_BITS-1:0] value,
                                         input logic [DIGIT_W-1:0] base_code);
      logic [VALUE_BITS-1:0] mag;
      logic [VALUE_BITS-1:0] radix;
      logic [VALUE_BITS-1:0] rem;
      logic [CHAR_W-1:0]     digits[$];
      ascii_char_type        entry;
      int                    n;

      mag   = value;
      radix = VALUE_BITS'(base_code);
      if (base_code < RADIX_MIN) begin
         radix = VALUE_BITS'(RADIX_MIN);
         clamped_count++;
      end else if (base_code > RADIX_MAX) begin
         radix = VALUE_BITS'(RADIX_MAX);
         clamped_count++;
      end
      if (radix == VALUE_BITS'(RADIX_DEC)) begin
         decimal_count++;
      end
      if (radix == VALUE_BITS'(RADIX_DEC) && value[VALUE_BITS-1]) begin
         mag = -value;
      end
      if (mag == '0) begin
         digits.push_front(CHAR_ZERO);
      end
      while (mag != '0) begin
         rem = mag % radix;
         if (rem > VALUE_BITS'(DIGIT_MAX_NUM)) begin
            digits.push_front(CHAR_W'(rem) - 7'd10 + CHAR_A);
         end else begin
            digits.push_front(CHAR_W'(rem) + CHAR_ZERO);
         end
         mag = mag / radix;
      end
      if (radix == VALUE_BITS'(RADIX_DEC) && value[VALUE_BITS-1]) begin
         digits.push_front(CHAR_MINUS);
         minus_count++;
      end
      n = digits.size();
      if (n > longest_string) begin
         longest_string = n;
      end
      for (int i = 0; i < n; i++) begin
         entry.code    = digits[i];
         entry.is_last = (i == n - 1);
         expected_chars.insert(expected_chars.size(), entry);
      end
   endfunction

   function automatic logic [VALUE_BITS-1:0] random_value();
      logic [VALUE_BITS-1:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: ;
         1: v = v >> $urandom_range(1, VALUE_BITS - 1);
         2: v = -(v >> $urandom_range(1, VALUE_BITS - 1));
         default: v = v >> $urandom_range(VALUE_BITS - 24, VALUE_BITS - 1);
      endcase
      return v;
   endfunction

   function automatic logic [DIGIT_W-1:0] random_base();
      case ($urandom_range(0, 9))
         0, 1, 2: return RADIX_DEC;
         3:       return DIGIT_W'($urandom_range(0, 63));
         default: return DIGIT_W'($urandom_range(RADIX_MIN, RADIX_MAX));
      endcase
   endfunction

   function automatic void add_item(input logic [VALUE_BITS-1:0] value,
                                    input logic [DIGIT_W-1:0] base_code,
                                    input bit drain_first);
      conversion_type item;
      item.value       = value;
      item.base        = base_code;
      item.drain_first = drain_first;
      pending_items.insert(pending_items.size(), item);
   endfunction

   // driver: one beat held on start until taken, bursts with random gaps
   always @(negedge clock) begin
      if (!reset) begin
         if (start && beats_taken != beats_issued) begin
            start <= 1'b1;
         end else if (gap_left > 0 || pending_items.size() == 0 ||
                      (pending_items[0].drain_first &&
                       (expected_chars.size() != 0 || busy))) begin
            if (gap_left > 0) begin
               gap_left--;
            end
            start     <= 1'b0;
            req_value <= {$urandom, $urandom};
            req_base  <= DIGIT_W'($urandom);
         end else begin
            conversion_type item;
            item = pending_items.pop_front();
            start     <= 1'b1;
            req_value <= item.value;
            req_base  <= item.base;
            beats_issued++;
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 8);
               case ($urandom_range(0, 3))
                  0: gap_left = 0;
                  1: gap_left = $urandom_range(1, 5);
                  2: gap_left = $urandom_range(6, 100);
                  default: gap_left = $urandom_range(100, 1500);
               endcase
            end
         end
      end
   end

   // monitor: check character strobes, then record a taken beat
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            chars_seen++;
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                         rsp_character, rsp_last));
            end else begin
               ascii_char_type want;
               want = expected_chars.pop_front();
               if (rsp_character !== want.code) begin
                  report_mismatch($sformatf("char 0x%02h, expected 0x%02h",
                                            rsp_character, want.code));
               end
               if (rsp_last !== want.is_last) begin
                  report_mismatch($sformatf("last %0b, expected %0b on char 0x%02h",
                                            rsp_last, want.is_last, want.code));
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            predict_ascii(req_value, req_base);
            beats_taken++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d beats pending", cycle_count,
                  total_items - beats_taken);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_value = '0;
      req_base  = '0;

      add_item('0, RADIX_DEC, 1'b0);
      add_item('0, RADIX_MIN, 1'b0);
      add_item('0, RADIX_MAX, 1'b0);
      add_item(64'd1, RADIX_MIN, 1'b0);
      add_item(64'd9, RADIX_DEC, 1'b0);
      add_item(64'd35, RADIX_MAX, 1'b0);
      add_item(64'd10, 6'd11, 1'b0);
      add_item(64'h7FFF_FFFF_FFFF_FFFF, RADIX_DEC, 1'b0);
      add_item(64'h8000_0000_0000_0000, RADIX_DEC, 1'b0);
      add_item(64'hFFFF_FFFF_FFFF_FFFF, RADIX_DEC, 1'b0);
      add_item(64'hFFFF_FFFF_FFFF_FFFF, 6'd16, 1'b0);
      add_item(64'hFFFF_FFFF_FFFF_FFFF, RADIX_MIN, 1'b0);
      add_item(64'h8000_0000_0000_0000, RADIX_MIN, 1'b0);
      add_item(-64'sd12345, 6'd8, 1'b0);
      add_item(-64'sd987654321, RADIX_DEC, 1'b0);
      add_item(64'd1000, RADIX_DEC, 1'b0);
      add_item(64'd255, 6'd0, 1'b0);
      add_item(64'd255, 6'd1, 1'b0);
      add_item(64'd12345, 6'd37, 1'b0);
      add_item(64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 1'b0);
      add_item(64'h0123_4567_89AB_CDEF, 6'd16, 1'b0);
      add_item(64'h0123_4567_89AB_CDEF, RADIX_MAX, 1'b0);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         add_item(random_value(), random_base(), (i == 0) || ($urandom_range(0, 39) == 0));
      end
      total_items = pending_items.size();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (beats_taken != total_items) @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Converted %0d values into %0d characters, longest string %0d.",
               beats_taken, chars_seen, longest_string);
      $display("Decimal: %0d (%0d signed negative); clamped base codes: %0d; cycles: %0d.",
               decimal_count, minus_count, clamped_count, cycle_count);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/ira_pkg.sv
rtl/ira_ram.sv
rtl/integer_to_radix_ascii.sv
bench/tb.sv
